// ===== hw/rtl/servo_frame_transaction_engine_assert.svh =====
// Assertion macros for the servo frame transaction engine.
// Used by sfte_dpath; no other dependencies.
`ifndef SERVO_FRAME_TRANSACTION_ENGINE_ASSERT_SVH
`define SERVO_FRAME_TRANSACTION_ENGINE_ASSERT_SVH

// Clocked check, disabled while reset is asserted (active low).
`define SFTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SFTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sfte_pkg.sv =====
// Shared types and constants of the servo frame transaction engine.
// No dependencies.
`default_nettype none

package sfte_pkg;

    localparam int BUF_BYTES_DEF = 64;
    localparam logic [15:0] TIMEOUT_RESET = 16'd60;
    localparam logic [15:0] REQ_HEADER = 16'h4C12;
    localparam logic [15:0] RSP_HEADER = 16'h1C05;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;
    // offsets and frame lengths: up to 255 + 259 in an address sum
    localparam int CW = 10;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_TX    = 2'd1;
    localparam logic [1:0] KIND_RX    = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    localparam logic [1:0] OK_TX      = 2'd0;
    localparam logic [1:0] OK_CONTENT = 2'd1;
    localparam logic [1:0] OK_STATUS  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

    typedef enum logic [2:0] {
        OFF_ZERO, OFF_ONE, OFF_THREE, OFF_FILL, OFF_CNT, OFF_CNT4, OFF_SUMIDX
    } off_t;

    typedef enum logic [2:0] {
        EM_NONE, EM_HDR, EM_TXBYTE, EM_TXSUM, EM_CONTENT, EM_OK, EM_TIMEOUT, EM_FULL
    } emit_t;

    typedef struct packed {
        logic       load_item;
        logic       start;
        logic       wr_byte;
        logic       tick_inc;
        logic       tx_step;
        logic       drop;
        logic       set_bad;
        logic       cap_b0;
        logic       cap_len;
        logic       clr_acc;
        logic       acc;
        logic       cnt_inc;
        logic       rd_en;
        off_t       off;
        emit_t      emit;
        logic       set_phase;
        logic [1:0] phase_val;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] phase;
        logic       want;
        logic       out_free;
        logic       fill_lt2;
        logic       fill_lt4;
        logic       fill_lt_flen;
        logic       fill_full;
        logic       hdr_ok;
        logic       hdr_last;
        logic       clen_tx_zero;
        logic       tx_last;
        logic       sum_done;
        logic       sum_match;
        logic       content_done;
        logic       clen_rx_zero;
        logic       timeout_hit;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfte_dpath.sv =====
// Datapath: item latch, receive buffer memory, counters, checksum and output word register.
// Depends on sfte_pkg and servo_frame_transaction_engine_assert.svh.
`default_nettype none

`include "servo_frame_transaction_engine_assert.svh"

module sfte_dpath #(
    parameter int BUF_BYTES = sfte_pkg::BUF_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire sfte_pkg::cmd_t cmd,
    output sfte_pkg::stat_t  stat,
    input  wire logic [15:0] timeout_ticks,
    input  wire logic [1:0]  s_kind,
    input  wire logic [7:0]  s_cmd,
    input  wire logic [7:0]  s_content_len,
    input  wire logic        s_want_response,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_status,
    output logic [7:0]       m_resp_cmd,
    output logic [7:0]       m_resp_len,
    output logic             m_saw_bad_sum,
    output logic             m_last
);
    localparam int PW = $clog2(BUF_BYTES);
    localparam int FW = $clog2(BUF_BYTES + 1);
    localparam int CW = sfte_pkg::CW;

    logic [7:0] mem [BUF_BYTES];

    logic [1:0]    kind_reg, phase_reg;
    logic [7:0]    icmd_reg, iclen_reg, ibyte_reg;
    logic          iwant_reg, want_reg, bad_reg;
    logic [FW-1:0] fill_reg;
    logic [PW-1:0] head_reg;
    logic [15:0]   tick_reg;
    logic [7:0]    rem_reg, txsum_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0]    acc_reg, b0_reg, clen_rx_reg, rcmd_reg, rd_reg;

    logic [CW-1:0] off, asum, fill_ext;
    logic [PW-1:0] addr, head_inc;
    logic [7:0]    hdr_byte;
    logic          out_free;

    assign fill_ext = CW'(fill_reg);
    assign out_free = !m_valid || m_ready;

    always_comb begin
        case (cmd.off)
            sfte_pkg::OFF_ZERO:   off = '0;
            sfte_pkg::OFF_ONE:    off = CW'(1);
            sfte_pkg::OFF_THREE:  off = CW'(3);
            sfte_pkg::OFF_FILL:   off = fill_ext;
            sfte_pkg::OFF_CNT:    off = cnt_reg;
            sfte_pkg::OFF_CNT4:   off = cnt_reg + CW'(4);
            sfte_pkg::OFF_SUMIDX: off = CW'(clen_rx_reg) + CW'(4);
            default:              off = '0;
        endcase
    end

    // circular buffer: offset from head, one wrap at most
    always_comb begin
        asum = CW'(head_reg) + off;
        if (asum >= CW'(BUF_BYTES)) begin
            asum = asum - CW'(BUF_BYTES);
        end
        addr = asum[PW-1:0];
        if (CW'(head_reg) + CW'(1) >= CW'(BUF_BYTES)) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg + PW'(1);
        end
    end

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    hdr_byte = sfte_pkg::REQ_HEADER[7:0];
            2'd1:    hdr_byte = sfte_pkg::REQ_HEADER[15:8];
            2'd2:    hdr_byte = icmd_reg;
            default: hdr_byte = iclen_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_byte) begin
            mem[addr] <= ibyte_reg;
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg  <= s_kind;
            icmd_reg  <= s_cmd;
            iclen_reg <= s_content_len;
            iwant_reg <= s_want_response;
            ibyte_reg <= s_data_byte;
        end
        if (cmd.cap_b0) begin
            b0_reg <= rd_reg;
        end
        if (cmd.cap_len) begin
            clen_rx_reg <= rd_reg;
        end
        if (cmd.clr_acc) begin
            acc_reg <= '0;
        end else if (cmd.acc) begin
            acc_reg <= acc_reg + rd_reg;
            if (cnt_reg == CW'(2)) begin
                rcmd_reg <= rd_reg;
            end
        end
        if (cmd.start || cmd.clr_acc) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc || cmd.acc) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sfte_pkg::PH_IDLE;
            fill_reg  <= '0;
            head_reg  <= '0;
            tick_reg  <= '0;
            rem_reg   <= '0;
            txsum_reg <= '0;
            want_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            if (cmd.start) begin
                fill_reg  <= '0;
                head_reg  <= '0;
                tick_reg  <= '0;
                bad_reg   <= 1'b0;
                want_reg  <= iwant_reg;
                rem_reg   <= iclen_reg;
                txsum_reg <= sfte_pkg::REQ_HEADER[7:0] + sfte_pkg::REQ_HEADER[15:8]
                             + icmd_reg + iclen_reg;
            end
            if (cmd.tx_step) begin
                txsum_reg <= txsum_reg + ibyte_reg;
                if (rem_reg != 8'd0) begin
                    rem_reg <= rem_reg - 8'd1;
                end
            end
            if (cmd.wr_byte) begin
                fill_reg <= fill_reg + FW'(1);
            end
            if (cmd.drop) begin
                fill_reg <= fill_reg - FW'(1);
                head_reg <= head_inc;
            end
            if (cmd.set_bad) begin
                bad_reg <= 1'b1;
            end
            if (cmd.tick_inc && tick_reg != sfte_pkg::TICK_MAX) begin
                tick_reg <= tick_reg + 16'd1;
            end
            if (cmd.set_phase) begin
                phase_reg <= cmd.phase_val;
            end
            if (cmd.emit != sfte_pkg::EM_NONE) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit != sfte_pkg::EM_NONE) begin
            m_out_kind    <= sfte_pkg::OK_TX;
            m_out_byte    <= '0;
            m_status      <= sfte_pkg::ST_OK;
            m_resp_cmd    <= '0;
            m_resp_len    <= '0;
            m_saw_bad_sum <= 1'b0;
            m_last        <= 1'b0;
            case (cmd.emit)
                sfte_pkg::EM_HDR:     m_out_byte <= hdr_byte;
                sfte_pkg::EM_TXBYTE:  m_out_byte <= ibyte_reg;
                sfte_pkg::EM_TXSUM: begin
                    m_out_byte <= txsum_reg;
                    m_last     <= 1'b1;
                end
                sfte_pkg::EM_CONTENT: begin
                    m_out_kind <= sfte_pkg::OK_CONTENT;
                    m_out_byte <= rd_reg;
                end
                sfte_pkg::EM_OK: begin
                    m_out_kind    <= sfte_pkg::OK_STATUS;
                    m_resp_cmd    <= rcmd_reg;
                    m_resp_len    <= clen_rx_reg;
                    m_saw_bad_sum <= bad_reg;
                    m_last        <= 1'b1;
                end
                sfte_pkg::EM_TIMEOUT: begin
                    m_out_kind    <= sfte_pkg::OK_STATUS;
                    m_status      <= sfte_pkg::ST_TIMEOUT;
                    m_saw_bad_sum <= bad_reg;
                    m_last        <= 1'b1;
                end
                sfte_pkg::EM_FULL: begin
                    m_out_kind    <= sfte_pkg::OK_STATUS;
                    m_status      <= sfte_pkg::ST_FULL;
                    m_saw_bad_sum <= bad_reg;
                    m_last        <= 1'b1;
                end
                default: m_out_byte <= '0;
            endcase
        end
    end

    always_comb begin
        stat.kind         = kind_reg;
        stat.phase        = phase_reg;
        stat.want         = want_reg;
        stat.out_free     = out_free;
        stat.fill_lt2     = fill_ext < CW'(2);
        stat.fill_lt4     = fill_ext < CW'(4);
        stat.fill_lt_flen = fill_ext < (CW'(rd_reg) + CW'(5));
        stat.fill_full    = fill_ext >= CW'(BUF_BYTES);
        stat.hdr_ok       = b0_reg == sfte_pkg::RSP_HEADER[7:0]
                            && rd_reg == sfte_pkg::RSP_HEADER[15:8];
        stat.hdr_last     = cnt_reg == CW'(3);
        stat.clen_tx_zero = iclen_reg == 8'd0;
        stat.tx_last      = rem_reg <= 8'd1;
        stat.sum_done     = cnt_reg == CW'(clen_rx_reg) + CW'(3);
        stat.sum_match    = rd_reg == acc_reg;
        stat.content_done = cnt_reg + CW'(1) == CW'(clen_rx_reg);
        stat.clen_rx_zero = clen_rx_reg == 8'd0;
        stat.timeout_hit  = tick_reg >= timeout_ticks;
    end

    `SFTE_ASSERT(a_fill_bound, aclk, aresetn, fill_ext <= CW'(BUF_BYTES), "fill beyond buffer")
    `SFTE_ASSERT(a_head_bound, aclk, aresetn, CW'(head_reg) < CW'(BUF_BYTES), "head out of range")
    `SFTE_ASSERT(a_emit_free, aclk, aresetn, (cmd.emit != sfte_pkg::EM_NONE) |-> out_free, "word overwritten")
    `SFTE_ASSERT(a_no_wr_full, aclk, aresetn, cmd.wr_byte |-> !stat.fill_full, "write to full buffer")

endmodule

`default_nettype wire

// ===== hw/rtl/sfte_ctrl.sv =====
// Controller state machine: sequences transmit, frame scan and status words.
// Depends on sfte_pkg.
`default_nettype none

module sfte_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire sfte_pkg::stat_t stat,
    output sfte_pkg::cmd_t      cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_TXHDR, S_TXBYTE, S_TXSUM, S_TICK,
        S_CHK, S_H0, S_H1, S_LEN, S_SRD, S_SACC, S_CRD, S_CMP,
        S_ERD, S_EWR, S_STOK, S_NOFRAME
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_IDLE;
                case (stat.kind)
                    sfte_pkg::KIND_START: begin
                        cmd.start = 1'b1;
                        state_next = S_TXHDR;
                    end
                    sfte_pkg::KIND_TX: begin
                        if (stat.phase == sfte_pkg::PH_SEND) state_next = S_TXBYTE;
                    end
                    sfte_pkg::KIND_RX: begin
                        if (stat.phase == sfte_pkg::PH_RECV) begin
                            cmd.wr_byte = !stat.fill_full;
                            cmd.off = sfte_pkg::OFF_FILL;
                            state_next = S_CHK;
                        end
                    end
                    default: begin
                        if (stat.phase == sfte_pkg::PH_RECV) begin
                            cmd.tick_inc = 1'b1;
                            state_next = S_TICK;
                        end
                    end
                endcase
            end
            S_TXHDR: begin
                if (stat.out_free) begin
                    cmd.emit = sfte_pkg::EM_HDR;
                    cmd.cnt_inc = 1'b1;
                    if (stat.hdr_last) begin
                        if (stat.clen_tx_zero) begin
                            state_next = S_TXSUM;
                        end else begin
                            cmd.set_phase = 1'b1;
                            cmd.phase_val = sfte_pkg::PH_SEND;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_TXBYTE: begin
                if (stat.out_free) begin
                    cmd.emit = sfte_pkg::EM_TXBYTE;
                    cmd.tx_step = 1'b1;
                    state_next = stat.tx_last ? S_TXSUM : S_IDLE;
                end
            end
            S_TXSUM: begin
                if (stat.out_free) begin
                    cmd.emit = sfte_pkg::EM_TXSUM;
                    cmd.set_phase = 1'b1;
                    cmd.phase_val = stat.want ? sfte_pkg::PH_RECV : sfte_pkg::PH_IDLE;
                    state_next = S_IDLE;
                end
            end
            S_TICK: begin
                if (!stat.timeout_hit) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit = sfte_pkg::EM_TIMEOUT;
                    cmd.set_phase = 1'b1;
                    cmd.phase_val = sfte_pkg::PH_IDLE;
                    state_next = S_IDLE;
                end
            end
            S_CHK: begin
                if (stat.fill_lt2) begin
                    state_next = S_NOFRAME;
                end else begin
                    cmd.rd_en = 1'b1;
                    cmd.off = sfte_pkg::OFF_ZERO;
                    state_next = S_H0;
                end
            end
            S_H0: begin
                cmd.cap_b0 = 1'b1;
                cmd.rd_en = 1'b1;
                cmd.off = sfte_pkg::OFF_ONE;
                state_next = S_H1;
            end
            S_H1: begin
                if (!stat.hdr_ok) begin
                    cmd.drop = 1'b1;
                    state_next = S_CHK;
                end else if (stat.fill_lt4) begin
                    state_next = S_NOFRAME;
                end else begin
                    cmd.rd_en = 1'b1;
                    cmd.off = sfte_pkg::OFF_THREE;
                    state_next = S_LEN;
                end
            end
            S_LEN: begin
                cmd.cap_len = 1'b1;
                cmd.clr_acc = 1'b1;
                state_next = stat.fill_lt_flen ? S_NOFRAME : S_SRD;
            end
            S_SRD: begin
                cmd.rd_en = 1'b1;
                cmd.off = sfte_pkg::OFF_CNT;
                state_next = S_SACC;
            end
            S_SACC: begin
                cmd.acc = 1'b1;
                state_next = stat.sum_done ? S_CRD : S_SRD;
            end
            S_CRD: begin
                cmd.rd_en = 1'b1;
                cmd.off = sfte_pkg::OFF_SUMIDX;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (stat.sum_match) begin
                    cmd.clr_acc = 1'b1;
                    state_next = stat.clen_rx_zero ? S_STOK : S_ERD;
                end else begin
                    cmd.drop = 1'b1;
                    cmd.set_bad = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_ERD: begin
                cmd.rd_en = 1'b1;
                cmd.off = sfte_pkg::OFF_CNT4;
                state_next = S_EWR;
            end
            S_EWR: begin
                if (stat.out_free) begin
                    cmd.emit = sfte_pkg::EM_CONTENT;
                    cmd.cnt_inc = 1'b1;
                    state_next = stat.content_done ? S_STOK : S_ERD;
                end
            end
            S_STOK: begin
                if (stat.out_free) begin
                    cmd.emit = sfte_pkg::EM_OK;
                    cmd.set_phase = 1'b1;
                    cmd.phase_val = sfte_pkg::PH_IDLE;
                    state_next = S_IDLE;
                end
            end
            S_NOFRAME: begin
                if (!stat.fill_full) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit = sfte_pkg::EM_FULL;
                    cmd.set_phase = 1'b1;
                    cmd.phase_val = sfte_pkg::PH_IDLE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/servo_frame_transaction_engine.sv =====
// Top level of the servo frame transaction engine: APB register, controller and datapath.
// Depends on sfte_pkg, sfte_ctrl and sfte_dpath.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    kind, cmd, content_len, want_response, data_byte
//   m_        out        m_valid/m_ready    out_kind, out_byte, status, resp_cmd, resp_len,
//                                           saw_bad_sum, last
//   apb       in         psel/penable       timeout_ticks at address 0
//
// An input word is accepted only in the idle state, so the engine finishes one word before it
// takes the next. A received byte takes a scan by the controller over the
// buffer memory's single read port: each header byte dropped, each checksum check and
// each content byte sent needs reads on that port.
// Synchronous active-low reset; no clearing pass. Output stalls hold the sequencer.
`default_nettype none

module servo_frame_transaction_engine #(
    parameter int BUF_BYTES = sfte_pkg::BUF_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [7:0]  s_cmd,
    input  wire logic [7:0]  s_content_len,
    input  wire logic        s_want_response,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_status,
    output logic [7:0]       m_resp_cmd,
    output logic [7:0]       m_resp_len,
    output logic             m_saw_bad_sum,
    output logic             m_last
);
    logic [15:0] timeout_reg;
    sfte_pkg::cmd_t  cmd;
    sfte_pkg::stat_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {16'd0, timeout_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= sfte_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && paddr == 3'd0) begin
            timeout_reg <= pwdata[15:0];
        end
    end

    sfte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sfte_dpath #(
        .BUF_BYTES (BUF_BYTES)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .timeout_ticks   (timeout_reg),
        .s_kind          (s_kind),
        .s_cmd           (s_cmd),
        .s_content_len   (s_content_len),
        .s_want_response (s_want_response),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_kind      (m_out_kind),
        .m_out_byte      (m_out_byte),
        .m_status        (m_status),
        .m_resp_cmd      (m_resp_cmd),
        .m_resp_len      (m_resp_len),
        .m_saw_bad_sum   (m_saw_bad_sum),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire

// ===== sim/servo_frame_transaction_engine_test.sv =====
// Testbench for the servo frame transaction engine: directed and random transactions.
// Depends on sfte_pkg and servo_frame_transaction_engine; predicts every result word itself.
`timescale 1ns / 100ps

module servo_frame_transaction_engine_test;

    localparam int          BUF_SIZE    = 64;
    localparam logic [2:0]  REG_TIMEOUT = 3'd0;
    localparam int          SETTLE      = 9000;
    localparam longint      CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] st;
        logic [7:0] rcmd;
        logic [7:0] rlen;
        logic       bad;
        logic       last;
    } result_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_kind = 0;
    logic [7:0]  s_cmd = 0, s_content_len = 0, s_data_byte = 0;
    logic        s_want_response = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_out_kind, m_status;
    logic [7:0]  m_out_byte, m_resp_cmd, m_resp_len;
    logic        m_saw_bad_sum, m_last;

    // predictor state
    logic [7:0]  rx_bytes[$];
    logic [1:0]  eng_phase;
    logic [15:0] ticks, timeout_val;
    logic [7:0]  tx_left, tx_sum;
    logic        resp_wanted, bad_seen;

    result_t     expected_words[$];
    int          errors = 0;
    int          words_sent = 0;
    bit          no_idle = 0;
    longint      cycles = 0;

    servo_frame_transaction_engine DUT (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 22);

    function automatic void push_word(logic [1:0] k, logic [7:0] d, logic [1:0] st,
                                      logic [7:0] rc, logic [7:0] rl, logic b, logic l);
        result_t r;
        r = '{k, d, st, rc, rl, b, l};
        expected_words.push_back(r);
    endfunction

    function automatic void close_request();
        push_word(sfte_pkg::OK_TX, tx_sum, sfte_pkg::ST_OK, 0, 0, 0, 1);
        eng_phase = resp_wanted ? sfte_pkg::PH_RECV : sfte_pkg::PH_IDLE;
    endfunction

    // returns 1 once a frame with a good checksum has been delivered
    function automatic bit scan_frames();
        int flen;
        logic [7:0] sum;
        forever begin
            while (rx_bytes.size() >= 2 &&
                   !(rx_bytes[0] == sfte_pkg::RSP_HEADER[7:0] &&
                     rx_bytes[1] == sfte_pkg::RSP_HEADER[15:8]))
                void'(rx_bytes.pop_front());
            if (rx_bytes.size() < 4) return 0;
            flen = int'(rx_bytes[3]) + 5;
            if (rx_bytes.size() < flen) return 0;
            sum = 0;
            for (int i = 0; i < flen - 1; i++) sum += rx_bytes[i];
            if (sum == rx_bytes[flen-1]) begin
                for (int i = 0; i < flen - 5; i++)
                    push_word(sfte_pkg::OK_CONTENT, rx_bytes[4+i], sfte_pkg::ST_OK,
                              0, 0, 0, 0);
                push_word(sfte_pkg::OK_STATUS, 0, sfte_pkg::ST_OK, rx_bytes[2], rx_bytes[3],
                          bad_seen, 1);
                return 1;
            end
            void'(rx_bytes.pop_front());
            bad_seen = 1;
        end
    endfunction

    function automatic void predict_engine(logic [1:0] k, logic [7:0] c, logic [7:0] len,
                                           logic w, logic [7:0] d);
        case (k)
            sfte_pkg::KIND_START: begin
                rx_bytes.delete();
                ticks = 0;
                bad_seen = 0;
                resp_wanted = w;
                tx_left = len;
                tx_sum = sfte_pkg::REQ_HEADER[7:0] + sfte_pkg::REQ_HEADER[15:8] + c + len;
                push_word(sfte_pkg::OK_TX, sfte_pkg::REQ_HEADER[7:0], sfte_pkg::ST_OK,
                          0, 0, 0, 0);
                push_word(sfte_pkg::OK_TX, sfte_pkg::REQ_HEADER[15:8], sfte_pkg::ST_OK,
                          0, 0, 0, 0);
                push_word(sfte_pkg::OK_TX, c, sfte_pkg::ST_OK, 0, 0, 0, 0);
                push_word(sfte_pkg::OK_TX, len, sfte_pkg::ST_OK, 0, 0, 0, 0);
                if (len == 0) close_request();
                else eng_phase = sfte_pkg::PH_SEND;
            end
            sfte_pkg::KIND_TX: begin
                if (eng_phase == sfte_pkg::PH_SEND) begin
                    tx_sum += d;
                    push_word(sfte_pkg::OK_TX, d, sfte_pkg::ST_OK, 0, 0, 0, 0);
                    if (tx_left > 0) tx_left--;
                    if (tx_left == 0) close_request();
                end
            end
            sfte_pkg::KIND_RX: begin
                if (eng_phase == sfte_pkg::PH_RECV) begin
                    if (rx_bytes.size() < BUF_SIZE) rx_bytes.push_back(d);
                    if (scan_frames()) eng_phase = sfte_pkg::PH_IDLE;
                    else if (rx_bytes.size() >= BUF_SIZE) begin
                        push_word(sfte_pkg::OK_STATUS, 0, sfte_pkg::ST_FULL, 0, 0, bad_seen, 1);
                        eng_phase = sfte_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
                if (eng_phase == sfte_pkg::PH_RECV) begin
                    if (ticks != sfte_pkg::TICK_MAX) ticks++;
                    if (ticks >= timeout_val) begin
                        push_word(sfte_pkg::OK_STATUS, 0, sfte_pkg::ST_TIMEOUT, 0, 0,
                                  bad_seen, 1);
                        eng_phase = sfte_pkg::PH_IDLE;
                    end
                end
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word kind %0d byte %02h", $time, m_out_kind,
                         m_out_byte);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (m_out_kind !== want.kind || m_out_byte !== want.data ||
                    m_status !== want.st || m_resp_cmd !== want.rcmd ||
                    m_resp_len !== want.rlen || m_saw_bad_sum !== want.bad ||
                    m_last !== want.last) begin
                    $display("%0t: mismatch expected k%0d b%02h s%0d c%02h l%02h bad%0d last%0d",
                             $time, want.kind, want.data, want.st, want.rcmd, want.rlen,
                             want.bad, want.last);
                    $display("%0t:            actual k%0d b%02h s%0d c%02h l%02h bad%0d last%0d",
                             $time, m_out_kind, m_out_byte, m_status, m_resp_cmd,
                             m_resp_len, m_saw_bad_sum, m_last);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(logic [1:0] k, logic [7:0] c, logic [7:0] len, logic w,
                             logic [7:0] d);
        @(negedge aclk);
        if (!no_idle && $urandom_range(0, 99) < 22) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1;
        s_kind <= k;
        s_cmd <= c;
        s_content_len <= len;
        s_want_response <= w;
        s_data_byte <= d;
        do @(posedge aclk); while (!s_ready);
        predict_engine(k, c, len, w, d);
        words_sent++;
    endtask

    task automatic start_req(logic [7:0] c, logic [7:0] len, logic w);
        send_word(sfte_pkg::KIND_START, c, len, w, $urandom);
    endtask

    task automatic rx_byte(logic [7:0] d);
        send_word(sfte_pkg::KIND_RX, $urandom, $urandom, $urandom, d);
    endtask

    task automatic tick();
        send_word(sfte_pkg::KIND_TICK, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic tx_bytes(int n);
        for (int i = 0; i < n; i++)
            send_word(sfte_pkg::KIND_TX, $urandom, $urandom, $urandom, $urandom);
    endtask

    // response frame; corrupt flips the checksum
    task automatic rx_frame(logic [7:0] c, int n, bit corrupt);
        logic [7:0] sum;
        logic [7:0] d;
        sum = sfte_pkg::RSP_HEADER[7:0] + sfte_pkg::RSP_HEADER[15:8] + c + 8'(n);
        rx_byte(sfte_pkg::RSP_HEADER[7:0]);
        rx_byte(sfte_pkg::RSP_HEADER[15:8]);
        rx_byte(c);
        rx_byte(8'(n));
        for (int i = 0; i < n; i++) begin
            d = $urandom;
            sum += d;
            rx_byte(d);
        end
        rx_byte(corrupt ? ~sum : sum);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_timeout(logic [15:0] v);
        drain();
        @(negedge aclk);
        psel <= 1; pwrite <= 1; paddr <= REG_TIMEOUT; pwdata <= {16'h0, v};
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        timeout_val = v;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic test_request_only();
        start_req(8'h00, 8'h00, 0);
        start_req(8'hFF, 8'h03, 0);
        send_word(sfte_pkg::KIND_TX, 8'h00, 8'h00, 1, 8'hFF);
        tx_bytes(2);
        // idle engine ignores these
        tx_bytes(1);
        rx_byte(8'h05);
        tick();
    endtask

    task automatic test_good_response();
        start_req(8'h5A, 8'h01, 1);
        tx_bytes(1);
        rx_byte(8'hAA);
        rx_byte(8'h05);
        rx_frame(8'hFF, 0, 0);
        start_req(8'h01, 8'h00, 1);
        rx_frame(8'h00, 3, 0);
    endtask

    task automatic test_bad_checksum();
        start_req(8'h10, 8'h00, 1);
        rx_frame(8'h22, 2, 1);
        rx_frame(8'h23, 1, 0);
    endtask

    task automatic test_timeout();
        set_timeout(16'd1);
        start_req(8'h33, 8'h00, 1);
        tick();
        set_timeout(16'hFFFF);
        start_req(8'h34, 8'h00, 1);
        tick();
        tick();
        rx_frame(8'h44, 1, 1);
        // start while receiving abandons the wait
        start_req(8'h35, 8'h02, 1);
        tx_bytes(1);
        start_req(8'h36, 8'h00, 0);
        set_timeout(16'd3);
        start_req(8'h37, 8'h00, 1);
        repeat (3) tick();
    endtask

    task automatic test_buffer_full();
        set_timeout(16'd60);
        start_req(8'h40, 8'h00, 1);
        rx_byte(sfte_pkg::RSP_HEADER[7:0]);
        rx_byte(sfte_pkg::RSP_HEADER[15:8]);
        rx_byte(8'h41);
        rx_byte(8'hFF);
        for (int i = 0; i < BUF_SIZE - 4; i++) rx_byte($urandom);
    endtask

    task automatic test_random();
        int goal, mode, n;
        bit alive;
        goal = words_sent + 330;
        while (words_sent < goal) begin
            if ($urandom_range(0, 14) == 0) begin
                set_timeout($urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom_range(1, 40)));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
            start_req($urandom, 8'(n), $urandom_range(0, 9) != 0);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 15) == 0) tick();
                tx_bytes(1);
            end
            mode = $urandom_range(0, 9);
            alive = 1;
            for (int j = 0; j < $urandom_range(0, 3); j++) begin
                if ($urandom_range(0, 7) == 0) tick();
                rx_byte($urandom_range(0, 3) == 0 ? sfte_pkg::RSP_HEADER[7:0] : 8'($urandom));
            end
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 10);
            if (mode <= 5) begin
                rx_frame($urandom, n, 0);
            end else if (mode <= 7) begin
                rx_frame($urandom, n, 1);
                rx_frame($urandom, $urandom_range(0, 6), 0);
            end else if (mode == 8 && timeout_val <= 45) begin
                repeat (timeout_val) tick();
            end
        end
        no_idle = 0;
    endtask

    initial begin
        rx_bytes.delete();
        eng_phase = sfte_pkg::PH_IDLE;
        ticks = 0; tx_left = 0; tx_sum = 0;
        resp_wanted = 0; bad_seen = 0;
        timeout_val = sfte_pkg::TIMEOUT_RESET;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        test_request_only();
        test_good_response();
        test_bad_checksum();
        test_buffer_full();
        test_timeout();
        test_random();
        drain();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
